### rtl/zip_local_header_walker_top_assert.svh
// Assertion macros for the local header walker.
// Included by the RTL modules that carry concurrent checks; needs clk and arst_n in scope.
`ifndef ZIP_LOCAL_HEADER_WALKER_TOP_ASSERT_SVH
`define ZIP_LOCAL_HEADER_WALKER_TOP_ASSERT_SVH

// check outside reset only
`define ZLHW_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// check at every edge, reset included
`define ZLHW_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/zlhw_pkg.sv
// Shared types and constants for the local header walker.
// No dependencies; used by zlhw_core and zip_local_header_walker_top.
package zlhw_pkg;

	localparam logic [31:0] LOCAL_SIG   = 32'h04034b50;
	localparam logic [15:0] MAX_ENTRIES = 16'd65535;
	localparam logic [4:0]  SIG_BYTES   = 5'd4;
	localparam logic [4:0]  HDR_LAST    = 5'd25;

	typedef enum logic [2:0] {
		PH_SIG,
		PH_HDR,
		PH_NAME,
		PH_EXTRA,
		PH_DATA
	} phase_t;

	typedef enum logic [1:0] {
		CAUSE_CLEAN,
		CAUSE_BAD_SIG,
		CAUSE_TRUNC
	} cause_t;

	typedef struct packed {
		logic        name_valid;
		logic [7:0]  name_char;
		logic        record_valid;
		logic [15:0] method_code;
		logic [31:0] packed_size;
		logic [31:0] unpacked_size;
		logic [15:0] name_length;
		logic [31:0] data_offset;
		logic [15:0] entry_number;
		logic        finished;
		logic [1:0]  finish_cause;
	} res_t;

	localparam int RES_W = $bits(res_t);

endpackage

### rtl/zlhw_skid.sv
// Output register with one skid slot, decoupling the walker from the master side.
// Generic payload width; no package dependencies.
module zlhw_skid #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [W-1:0] in_data,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [W-1:0] out_data
);

	logic         out_valid_q;
	logic [W-1:0] out_data_q;
	logic         skid_valid_q;
	logic [W-1:0] skid_data_q;
	logic         load;

	assign in_ready  = !skid_valid_q;
	assign load      = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			// drain the skid slot first, else take the new beat directly
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= load;
			end
		end else if (load) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || out_ready) begin
			out_data_q <= skid_valid_q ? skid_data_q : in_data;
		end
		if (load && out_valid_q && !out_ready) begin
			skid_data_q <= in_data;
		end
	end

endmodule

### rtl/zlhw_core.sv
// Per-byte walker state and next-state logic: signature check, header unpack, skips.
// Depends on zlhw_pkg and the assertion macro header.
`include "zip_local_header_walker_top_assert.svh"

module zlhw_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          beat_acc,
	input  logic [7:0]    data_byte,
	input  logic          last_byte,
	output logic          res_valid,
	output zlhw_pkg::res_t res
);
	import zlhw_pkg::*;

	phase_t      phase_q, phase_n;
	logic [4:0]  fcnt_q, fcnt_n;
	logic [31:0] sig_q, sig_n;
	logic [15:0] method_q, method_n;
	logic [31:0] packed_q, packed_n;
	logic [31:0] unpacked_q, unpacked_n;
	logic [15:0] name_len_q, name_len_n;
	logic [15:0] extra_len_q, extra_len_n;
	logic [31:0] skip_q, skip_n;
	logic [31:0] pos_q;
	logic [15:0] entry_q;
	logic        halted_q;

	logic        step;
	logic        emit;
	logic        bad;
	logic        clean;
	logic [4:0]  fcnt_inc;
	logic [31:0] skip_dec;
	phase_t      emit_phase;

	assign step      = beat_acc && !halted_q;
	assign res_valid = step;
	assign fcnt_inc  = fcnt_q + 5'd1;
	assign skip_dec  = (skip_q == 32'd0) ? 32'd0 : skip_q - 32'd1;
	assign emit_phase = (packed_q != 32'd0) ? PH_DATA : PH_SIG;

	// next state
	always_comb begin
		phase_n     = phase_q;
		fcnt_n      = fcnt_q;
		sig_n       = sig_q;
		method_n    = method_q;
		packed_n    = packed_q;
		unpacked_n  = unpacked_q;
		name_len_n  = name_len_q;
		extra_len_n = extra_len_q;
		skip_n      = skip_q;
		emit        = 1'b0;
		bad         = 1'b0;
		case (phase_q)
			PH_SIG: begin
				sig_n  = {data_byte, sig_q[31:8]};
				fcnt_n = fcnt_inc;
				if (fcnt_inc >= SIG_BYTES) begin
					fcnt_n = 5'd0;
					if (sig_n == LOCAL_SIG) begin
						phase_n = PH_HDR;
					end else begin
						bad = 1'b1;
					end
				end
			end
			PH_HDR: begin
				case (fcnt_q)
					5'd4:  method_n[7:0]     = data_byte;
					5'd5:  method_n[15:8]    = data_byte;
					5'd14: packed_n[7:0]     = data_byte;
					5'd15: packed_n[15:8]    = data_byte;
					5'd16: packed_n[23:16]   = data_byte;
					5'd17: packed_n[31:24]   = data_byte;
					5'd18: unpacked_n[7:0]   = data_byte;
					5'd19: unpacked_n[15:8]  = data_byte;
					5'd20: unpacked_n[23:16] = data_byte;
					5'd21: unpacked_n[31:24] = data_byte;
					5'd22: name_len_n[7:0]   = data_byte;
					5'd23: name_len_n[15:8]  = data_byte;
					5'd24: extra_len_n[7:0]  = data_byte;
					5'd25: extra_len_n[15:8] = data_byte;
					default: ;
				endcase
				fcnt_n = fcnt_inc;
				if (fcnt_q >= HDR_LAST) begin
					fcnt_n = 5'd0;
					if (name_len_n != 16'd0) begin
						phase_n = PH_NAME;
						skip_n  = {16'd0, name_len_n};
					end else if (extra_len_n != 16'd0) begin
						phase_n = PH_EXTRA;
						skip_n  = {16'd0, extra_len_n};
					end else begin
						emit = 1'b1;
					end
				end
			end
			PH_NAME: begin
				skip_n = skip_dec;
				if (skip_dec == 32'd0) begin
					if (extra_len_q != 16'd0) begin
						phase_n = PH_EXTRA;
						skip_n  = {16'd0, extra_len_q};
					end else begin
						emit = 1'b1;
					end
				end
			end
			PH_EXTRA: begin
				skip_n = skip_dec;
				if (skip_dec == 32'd0) begin
					emit = 1'b1;
				end
			end
			default: begin
				skip_n = skip_dec;
				if (skip_dec == 32'd0) begin
					phase_n = PH_SIG;
					fcnt_n  = 5'd0;
				end
			end
		endcase
		// entry complete: skip the data, or expect the next signature at once
		if (emit) begin
			phase_n = emit_phase;
			if (emit_phase == PH_DATA) begin
				skip_n = packed_q;
			end else begin
				fcnt_n = 5'd0;
			end
		end
	end

	assign clean = (phase_n == PH_DATA) || (phase_n == PH_SIG && fcnt_n == 5'd0);

	// result of this beat
	always_comb begin
		res = '0;
		if (phase_q == PH_NAME) begin
			res.name_valid = 1'b1;
			res.name_char  = data_byte;
		end
		if (emit) begin
			res.record_valid  = 1'b1;
			res.method_code   = method_n;
			res.packed_size   = packed_n;
			res.unpacked_size = unpacked_n;
			res.name_length   = name_len_n;
			res.data_offset   = (pos_q == '1) ? pos_q : pos_q + 32'd1;
			res.entry_number  = entry_q;
		end
		if (bad) begin
			res.finished     = 1'b1;
			res.finish_cause = CAUSE_BAD_SIG;
		end else if (last_byte) begin
			res.finished     = 1'b1;
			res.finish_cause = clean ? CAUSE_CLEAN : CAUSE_TRUNC;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_SIG;
			fcnt_q      <= 5'd0;
			sig_q       <= 32'd0;
			method_q    <= 16'd0;
			packed_q    <= 32'd0;
			unpacked_q  <= 32'd0;
			name_len_q  <= 16'd0;
			extra_len_q <= 16'd0;
			skip_q      <= 32'd0;
			pos_q       <= 32'd0;
			entry_q     <= 16'd0;
			halted_q    <= 1'b0;
		end else if (step) begin
			phase_q     <= phase_n;
			fcnt_q      <= fcnt_n;
			sig_q       <= sig_n;
			method_q    <= method_n;
			packed_q    <= packed_n;
			unpacked_q  <= unpacked_n;
			name_len_q  <= name_len_n;
			extra_len_q <= extra_len_n;
			skip_q      <= skip_n;
			if (pos_q != '1) begin
				pos_q <= pos_q + 32'd1;
			end
			if (emit && entry_q < MAX_ENTRIES) begin
				entry_q <= entry_q + 16'd1;
			end
			halted_q <= bad || last_byte;
		end
	end

	`ZLHW_ASSERT(a_halt_silent, halted_q |-> !res_valid, "result produced after walk halted")
	`ZLHW_ASSERT(a_halt_cause, $rose(halted_q) |-> $past(res_valid && res.finished),
		"walk halted without a finishing result")
	`ZLHW_ASSERT(a_record_not_bad, (res_valid && res.record_valid) |->
		!(res.finished && res.finish_cause == CAUSE_BAD_SIG), "record on a bad signature")
	`ZLHW_ASSERT(a_pos_advance, (step && pos_q != '1) |=> pos_q == $past(pos_q) + 32'd1,
		"byte position did not advance")

endmodule

### rtl/zip_local_header_walker_top.sv
// A result reaches the master side from the output register, via the skid slot while it stalls.
// Throughput: one byte per cycle; the output register plus one skid slot keep the slave
// side ready while a result waits, so ready drops only when both are full.
// A beat taken after the walk has finished produces no result.
// Reset (arst_n low, asynchronous) returns the walk to the signature phase, clears counters.
module zip_local_header_walker_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,  // [7:0] data_byte
	input  logic         s_axis_tlast,  // last_byte
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// [7:0] name_char, [23:8] method_code, [55:24] packed_size, [87:56] unpacked_size,
	// [103:88] name_length, [135:104] data_offset, [151:136] entry_number,
	// [153:152] finish_cause, [159:154] zero
	output logic [159:0] m_axis_tdata,
	output logic [1:0]   m_axis_tuser,  // [0] name_valid, [1] record_valid
	output logic         m_axis_tlast   // finished
);
	import zlhw_pkg::*;

	logic             beat_acc;
	logic             res_valid;
	res_t             res;
	logic             skid_ready;
	logic [RES_W-1:0] out_bits;
	res_t             out_res;

	assign s_axis_tready = skid_ready;
	assign beat_acc      = s_axis_tvalid && skid_ready;

	zlhw_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.beat_acc  (beat_acc),
		.data_byte (s_axis_tdata),
		.last_byte (s_axis_tlast),
		.res_valid (res_valid),
		.res       (res)
	);

	zlhw_skid #(
		.W (RES_W)
	) u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (res_valid),
		.in_ready  (skid_ready),
		.in_data   (res),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (out_bits)
	);

	assign out_res = res_t'(out_bits);

	assign m_axis_tdata = {6'd0, out_res.finish_cause, out_res.entry_number,
		out_res.data_offset, out_res.name_length, out_res.unpacked_size,
		out_res.packed_size, out_res.method_code, out_res.name_char};
	assign m_axis_tuser = {out_res.record_valid, out_res.name_valid};
	assign m_axis_tlast = out_res.finished;

endmodule

### tb/sv/zlhw_walk_checker.sv
// Scoreboard for the ZIP local header walker: predicts one result beat per byte beat up to the halt
// and compares the master-side beats against it. Depends on zlhw_pkg for codes and the result layout.
`timescale 1ns / 100ps

module zlhw_walk_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,
	input  logic         s_axis_tlast,
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic [159:0] m_axis_tdata,
	input  logic [1:0]   m_axis_tuser,
	input  logic         m_axis_tlast,
	output int           mismatches,
	output int           pending
);
	import zlhw_pkg::*;

	// walk state
	phase_t      walk_phase;
	logic [4:0]  field_cnt;
	logic [31:0] sig_shift;
	logic [15:0] held_method;
	logic [31:0] held_packed;
	logic [31:0] held_unpacked;
	logic [15:0] held_name_len;
	logic [15:0] held_extra_len;
	logic [31:0] skip_left;
	logic [31:0] byte_pos;
	logic [15:0] entry_cnt;
	logic        walk_halted;

	res_t step_res;
	res_t want;
	res_t walk_results[$];
	int   fail_total;

	task automatic issue_entry_record(input logic [31:0] pos);
		step_res.record_valid  = 1'b1;
		step_res.method_code   = held_method;
		step_res.packed_size   = held_packed;
		step_res.unpacked_size = held_unpacked;
		step_res.name_length   = held_name_len;
		step_res.data_offset   = (pos == 32'hFFFF_FFFF) ? pos : pos + 32'd1;
		step_res.entry_number  = entry_cnt;
		if (entry_cnt < MAX_ENTRIES)
			entry_cnt = entry_cnt + 16'd1;
		if (held_packed != 32'd0) begin
			walk_phase = PH_DATA;
			skip_left  = held_packed;
		end else begin
			walk_phase = PH_SIG;
			field_cnt  = 5'd0;
		end
	endtask

	task automatic finish_name(input logic [31:0] pos);
		if (held_extra_len != 16'd0) begin
			walk_phase = PH_EXTRA;
			skip_left  = {16'd0, held_extra_len};
		end else begin
			issue_entry_record(pos);
		end
	endtask

	task automatic walk_byte(input logic [7:0] b, input logic last);
		logic [31:0] pos;
		logic        bad_sig;
		int          k;
		if (!walk_halted) begin
			pos      = byte_pos;
			bad_sig  = 1'b0;
			step_res = '0;
			case (walk_phase)
				PH_SIG: begin
					sig_shift = {b, sig_shift[31:8]};
					field_cnt = field_cnt + 5'd1;
					if (field_cnt >= SIG_BYTES) begin
						field_cnt = 5'd0;
						if (sig_shift == LOCAL_SIG)
							walk_phase = PH_HDR;
						else
							bad_sig = 1'b1;
					end
				end
				PH_HDR: begin
					k = int'(field_cnt);
					if (k == 4 || k == 5)
						held_method[8*(k-4) +: 8] = b;
					else if (k >= 14 && k <= 17)
						held_packed[8*(k-14) +: 8] = b;
					else if (k >= 18 && k <= 21)
						held_unpacked[8*(k-18) +: 8] = b;
					else if (k == 22 || k == 23)
						held_name_len[8*(k-22) +: 8] = b;
					else if (k == 24 || k == 25)
						held_extra_len[8*(k-24) +: 8] = b;
					if (k == int'(HDR_LAST)) begin
						field_cnt = 5'd0;
						if (held_name_len != 16'd0) begin
							walk_phase = PH_NAME;
							skip_left  = {16'd0, held_name_len};
						end else begin
							finish_name(pos);
						end
					end else begin
						field_cnt = field_cnt + 5'd1;
					end
				end
				PH_NAME: begin
					step_res.name_valid = 1'b1;
					step_res.name_char  = b;
					if (skip_left != 32'd0)
						skip_left = skip_left - 32'd1;
					if (skip_left == 32'd0)
						finish_name(pos);
				end
				PH_EXTRA: begin
					if (skip_left != 32'd0)
						skip_left = skip_left - 32'd1;
					if (skip_left == 32'd0)
						issue_entry_record(pos);
				end
				default: begin
					if (skip_left != 32'd0)
						skip_left = skip_left - 32'd1;
					if (skip_left == 32'd0) begin
						walk_phase = PH_SIG;
						field_cnt  = 5'd0;
					end
				end
			endcase

			if (byte_pos != 32'hFFFF_FFFF)
				byte_pos = byte_pos + 32'd1;

			// a bad signature outranks the last-byte mark
			if (bad_sig) begin
				step_res.finished     = 1'b1;
				step_res.finish_cause = CAUSE_BAD_SIG;
				walk_halted           = 1'b1;
			end else if (last) begin
				step_res.finished     = 1'b1;
				step_res.finish_cause = (walk_phase == PH_DATA ||
					(walk_phase == PH_SIG && field_cnt == 5'd0)) ? CAUSE_CLEAN : CAUSE_TRUNC;
				walk_halted           = 1'b1;
			end
			walk_results.push_back(step_res);
		end
	endtask

	task automatic check_field(input string field, input logic [31:0] exp_val,
			input logic [31:0] got_val);
		if (exp_val !== got_val) begin
			$error("%s: expected 0x%0h, got 0x%0h", field, exp_val, got_val);
			fail_total++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_phase     = PH_SIG;
			field_cnt      = 5'd0;
			sig_shift      = 32'd0;
			held_method    = 16'd0;
			held_packed    = 32'd0;
			held_unpacked  = 32'd0;
			held_name_len  = 16'd0;
			held_extra_len = 16'd0;
			skip_left      = 32'd0;
			byte_pos       = 32'd0;
			entry_cnt      = 16'd0;
			walk_halted    = 1'b0;
			fail_total     = 0;
			walk_results.delete();
			mismatches <= 0;
			pending    <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				walk_byte(s_axis_tdata, s_axis_tlast);
			if (m_axis_tvalid && m_axis_tready) begin
				if (walk_results.size() == 0) begin
					$error("result beat with no byte beat waiting for it");
					fail_total++;
				end else begin
					want = walk_results.pop_front();
					check_field("name_valid", 32'(want.name_valid), 32'(m_axis_tuser[0]));
					check_field("name_char", 32'(want.name_char), 32'(m_axis_tdata[7:0]));
					check_field("record_valid", 32'(want.record_valid),
						32'(m_axis_tuser[1]));
					check_field("method_code", 32'(want.method_code),
						32'(m_axis_tdata[23:8]));
					check_field("packed_size", want.packed_size, m_axis_tdata[55:24]);
					check_field("unpacked_size", want.unpacked_size, m_axis_tdata[87:56]);
					check_field("name_length", 32'(want.name_length),
						32'(m_axis_tdata[103:88]));
					check_field("data_offset", want.data_offset, m_axis_tdata[135:104]);
					check_field("entry_number", 32'(want.entry_number),
						32'(m_axis_tdata[151:136]));
					check_field("finished", 32'(want.finished), 32'(m_axis_tlast));
					check_field("finish_cause", 32'(want.finish_cause),
						32'(m_axis_tdata[153:152]));
					check_field("tdata pad", 32'd0, 32'(m_axis_tdata[159:154]));
				end
			end
			mismatches <= fail_total;
			pending    <= walk_results.size();
		end
	end

endmodule

### tb/sv/zip_local_header_walker_top_test.sv
// Testbench top for the ZIP local header walker: builds one archive byte stream, drives it
// with random gaps and back-pressure, and gives the verdict. Depends on zlhw_pkg and zlhw_walk_checker.
`timescale 1ns / 100ps

module zip_local_header_walker_top_test;
	import zlhw_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;

	typedef enum {
		END_BOUNDARY,
		END_ON_RECORD,
		END_IN_DATA,
		END_IN_SIG,
		END_IN_HDR,
		END_IN_NAME,
		END_IN_EXTRA,
		END_BAD_SIG,
		END_BAD_SIG_LAST
	} archive_end_t;

	logic         clk = 1'b0;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [7:0]   s_axis_tdata;
	logic         s_axis_tlast;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [159:0] m_axis_tdata;
	logic [1:0]   m_axis_tuser;
	logic         m_axis_tlast;

	int mismatches;
	int pending;
	int idle_mode = 0;
	int stall_cycles = 0;

	logic [7:0] archive_bytes[$];
	logic       archive_last[$];

	always #4 clk = ~clk;

	zip_local_header_walker_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	zlhw_walk_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.mismatches    (mismatches),
		.pending       (pending)
	);

	// Append the first keep bytes of one local entry: signature, fixed header, name, extra, data.
	task automatic push_entry(input logic [15:0] method, input logic [31:0] packed_len,
			input logic [31:0] unpacked_len, input logic [15:0] name_len,
			input logic [15:0] xfield_len, input int keep);
		logic [7:0] b;
		int         i;
		for (i = 0; i < keep; i++) begin
			b = 8'($urandom);
			if (i < 4)
				b = LOCAL_SIG[8*i +: 8];
			else if (i == 8 || i == 9)
				b = method[8*(i-8) +: 8];
			else if (i >= 18 && i <= 21)
				b = packed_len[8*(i-18) +: 8];
			else if (i >= 22 && i <= 25)
				b = unpacked_len[8*(i-22) +: 8];
			else if (i == 26 || i == 27)
				b = name_len[8*(i-26) +: 8];
			else if (i == 28 || i == 29)
				b = xfield_len[8*(i-28) +: 8];
			archive_bytes.push_back(b);
			archive_last.push_back(1'b0);
		end
	endtask

	always @(posedge clk) begin
		m_axis_tready <= $urandom_range(0, 99) >= (idle_mode == 0 ? 69 : idle_mode == 1 ? 33 : 0);
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		logic [15:0]  nlen;
		logic [15:0]  xlen;
		logic [31:0]  plen;
		logic [7:0]   flip;
		archive_end_t end_kind;
		int           lane;
		int           sent;
		int           total;
		int           send_idle_pct;

		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = 8'd0;
		s_axis_tlast  = 1'b0;

		// empty entry, then extreme method/size values, extra without name, name plus extra
		push_entry(16'h0000, 32'd0, 32'd0, 16'd0, 16'd0, 30);
		push_entry(16'hFFFF, 32'd1, 32'hFFFF_FFFF, 16'd1, 16'd0, 32);
		push_entry(16'h0008, 32'd0, 32'd0, 16'd0, 16'd1, 31);
		push_entry(16'h8000, 32'd3, 32'h8000_0000, 16'd3, 16'd2, 38);

		while (archive_bytes.size() < 1700) begin
			nlen = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 10));
			xlen = ($urandom_range(0, 2) == 0) ? 16'($urandom_range(1, 8)) : 16'd0;
			plen = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom_range(1, 24);
			push_entry(16'($urandom), plen, $urandom, nlen, xlen,
				int'(30 + nlen + xlen + plen));
		end

		// one archive per run, so pick how this one ends
		end_kind = archive_end_t'($urandom_range(0, 8));
		nlen = 16'($urandom_range(0, 6));
		xlen = 16'($urandom_range(0, 4));
		plen = $urandom_range(0, 12);
		case (end_kind)
			END_BOUNDARY: begin
			end
			END_ON_RECORD: begin
				if ($urandom_range(0, 1) == 1)
					plen = $urandom;
				push_entry(16'($urandom), plen, $urandom, nlen, xlen, int'(30 + nlen + xlen));
			end
			END_IN_DATA: begin
				plen = ($urandom_range(0, 1) == 1) ? 32'hFFFF_FFFF : $urandom_range(2, 40);
				push_entry(16'($urandom), plen, $urandom, nlen, xlen,
					int'(30 + nlen + xlen + $urandom_range(1, (plen > 21) ? 20 : plen - 1)));
			end
			END_IN_SIG: begin
				push_entry(16'd0, 32'd0, 32'd0, 16'd0, 16'd0, int'($urandom_range(1, 3)));
			end
			END_IN_HDR: begin
				push_entry(16'($urandom), plen, $urandom, nlen, xlen,
					int'($urandom_range(5, 29)));
			end
			END_IN_NAME: begin
				nlen = ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'($urandom_range(1, 12));
				push_entry(16'($urandom), plen, $urandom, nlen, xlen,
					int'(30 + $urandom_range(0, (nlen > 12) ? 12 : nlen - 1)));
			end
			END_IN_EXTRA: begin
				xlen = ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'($urandom_range(1, 12));
				push_entry(16'($urandom), plen, $urandom, nlen, xlen,
					int'(30 + nlen + $urandom_range(0, (xlen > 12) ? 12 : xlen - 1)));
			end
			default: begin
				// corrupt one signature byte
				push_entry(16'd0, 32'd0, 32'd0, 16'd0, 16'd0, 4);
				lane = $urandom_range(0, 3);
				flip = 8'($urandom_range(1, 255));
				archive_bytes[archive_bytes.size() - 4 + lane] =
					archive_bytes[archive_bytes.size() - 4 + lane] ^ flip;
			end
		endcase
		if (end_kind != END_BAD_SIG)
			archive_last[archive_last.size() - 1] = 1'b1;

		// bytes after the walk has stopped must be swallowed
		repeat ($urandom_range(1, 5)) begin
			archive_bytes.push_back(8'($urandom));
			archive_last.push_back(1'($urandom_range(0, 1)));
		end
		total = archive_bytes.size();

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		sent = 0;
		while (sent < total) begin
			@(posedge clk);
			if (s_axis_tvalid && s_axis_tready)
				sent++;
			idle_mode <= (sent * 3) / total;
			case ((sent * 3) / total)
				0:       send_idle_pct = 33;
				1:       send_idle_pct = 69;
				default: send_idle_pct = 0;
			endcase
			if (s_axis_tvalid && !s_axis_tready) begin
				// hold the beat until it is taken
			end else if (sent < total && $urandom_range(0, 99) >= send_idle_pct) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata  <= archive_bytes[sent];
				s_axis_tlast  <= archive_last[sent];
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end

		do
			@(posedge clk);
		while (pending != 0);
		repeat (8) @(posedge clk);

		if (mismatches == 0 && pending == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
